### rtl/core/block_frame_delay_address_core_macros.svh
// Assertion macros shared by the frame delay address core.
`ifndef BLOCK_FRAME_DELAY_ADDRESS_CORE_MACROS_SVH
`define BLOCK_FRAME_DELAY_ADDRESS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BFDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bfda: check failed");
`define BFDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bfda: invariant failed");
`else
`define BFDA_ASSERT(lbl, prop)
`define BFDA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/core/bfda_pkg.sv
// Types and constants of the frame delay address core.
package bfda_pkg;

  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned OFFSET_W   = 26;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned ROOT_W     = 24;
  localparam int unsigned ROOT_OUT_W = 12;
  localparam logic [ROOT_W-1:0] ROOT_TOP_BIT = 24'h40_0000;

  // Input function codes
  localparam logic [1:0] FUNC_BUILD   = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

  // Delay pattern codes
  localparam logic [2:0] MODE_RANDOM  = 3'd1;
  localparam logic [2:0] MODE_VSTRIPE = 3'd2;
  localparam logic [2:0] MODE_HSTRIPE = 3'd3;
  localparam logic [2:0] MODE_RINGS   = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_BLOCK_SIZE  = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd2;
  localparam logic [2:0] REG_MAP_COLS    = 3'd3;
  localparam logic [2:0] REG_MAP_ROWS    = 3'd4;
  localparam logic [2:0] REG_SEED        = 3'd5;

  // Register reset values
  localparam logic [2:0]  RST_MODE        = 3'd3;
  localparam logic [6:0]  RST_BLOCK_SIZE  = 7'd2;
  localparam logic [12:0] RST_FRAME_WIDTH = 13'd640;
  localparam logic [11:0] RST_MAP_COLS    = 12'd320;
  localparam logic [11:0] RST_MAP_ROWS    = 12'd240;
  localparam logic [31:0] RST_SEED        = 32'd0;

  // Linear congruential generator
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;

  typedef enum logic [1:0] {
    OP_BUILD   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_ROOT = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  block_size;
    logic [12:0] frame_width;
    logic [11:0] map_cols;
    logic [11:0] map_rows;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              first;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [SLOT_W-1:0]   delay;
  } res_t;

endpackage

### rtl/core/bfda_fifo.sv
// Small register queue used between the front, the back and the result side.
module bfda_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/bfda_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module bfda_sqrt import bfda_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ROOT_W-1:0]     value_i,
  output logic                  busy_o,
  output logic [ROOT_OUT_W-1:0] root_o
);

  logic              busy_q;
  logic [ROOT_W-1:0] rem_q, res_q, bit_q;
  logic [ROOT_W-1:0] trial, res_shift;

  assign trial     = res_q | bit_q;
  assign res_shift = res_q >> 1;
  assign busy_o    = busy_q;
  assign root_o    = res_q[ROOT_OUT_W-1:0];

  // Hold busy from start until the last bit pair is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (bit_q == ROOT_W'(1))) begin
      busy_q <= 1'b0;
    end
  end

  // Try one root bit per cycle: subtract the trial value where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      bit_q <= ROOT_TOP_BIT;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= res_shift | bit_q;
      end else begin
        res_q <= res_shift;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

### rtl/core/bfda_front.sv
// Front end: configuration registers, item classification and command queue.
module bfda_front import bfda_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item side
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            func_i,
  input  logic                  first_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [COORD_W-1:0]    col_i,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // back end side
  output cfg_t                  cfg_o,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_pop_i
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;
  cmd_t       cmd_in;
  logic       cmd_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= RST_MODE;
      cfg_q.block_size  <= RST_BLOCK_SIZE;
      cfg_q.frame_width <= RST_FRAME_WIDTH;
      cfg_q.map_cols    <= RST_MAP_COLS;
      cfg_q.map_rows    <= RST_MAP_ROWS;
      cfg_q.seed        <= RST_SEED;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:        cfg_q.mode        <= pwdata[2:0];
        REG_BLOCK_SIZE:  cfg_q.block_size  <= pwdata[6:0];
        REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[12:0];
        REG_MAP_COLS:    cfg_q.map_cols    <= pwdata[11:0];
        REG_MAP_ROWS:    cfg_q.map_rows    <= pwdata[11:0];
        REG_SEED:        cfg_q.seed        <= pwdata;
        default: ;
      endcase
    end
  end

  // Return register contents on reads
  always_comb begin
    unique case (reg_idx)
      REG_MODE:        prdata = APB_DATA_W'(cfg_q.mode);
      REG_BLOCK_SIZE:  prdata = APB_DATA_W'(cfg_q.block_size);
      REG_FRAME_WIDTH: prdata = APB_DATA_W'(cfg_q.frame_width);
      REG_MAP_COLS:    prdata = APB_DATA_W'(cfg_q.map_cols);
      REG_MAP_ROWS:    prdata = APB_DATA_W'(cfg_q.map_rows);
      REG_SEED:        prdata = cfg_q.seed;
      default:         prdata = '0;
    endcase
  end

  // Classify the incoming item
  always_comb begin
    cmd_in.first = first_i;
    cmd_in.row   = row_i;
    cmd_in.col   = col_i;
    unique case (func_i)
      FUNC_BUILD:   cmd_in.op = OP_BUILD;
      FUNC_ADVANCE: cmd_in.op = OP_ADVANCE;
      FUNC_LOOKUP:  cmd_in.op = OP_LOOKUP;
      default:      cmd_in.op = OP_NONE;
    endcase
  end

  // Queue classified commands for the back end
  bfda_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

### rtl/core/bfda_back.sv
// Back end: address arithmetic, delay map memory, ring head and result queue.
`include "block_frame_delay_address_core_macros.svh"
module bfda_back import bfda_pkg::*; #(
  parameter int unsigned QueueDepth = 71,
  parameter int unsigned MapEntries = 16384
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_empty_o,
  output res_t res_o,
  input  logic res_pop_i
);

  localparam int unsigned AddrW = $clog2(MapEntries);
  localparam logic [SLOT_W-1:0] QdMax = SLOT_W'(QueueDepth - 1);

  state_e state_q, state_d;

  // Registers loaded when a command is taken from the queue
  op_e         op_q;
  logic [17:0] colbs_q, rowbs_q;
  logic [23:0] idx_q;
  logic        in_map_q;
  logic [11:0] adx_q, ady_q;
  logic [31:0] lcg_q, lcg_d;
  // Registers loaded in the execute step, and the ring head
  logic [OFFSET_W-1:0] off_q;
  logic [5:0]          rnd_q;
  logic [SLOT_W-1:0]   mem_rd_q;
  logic [SLOT_W-1:0]   head_q, head_d;

  logic [SLOT_W-1:0] delay_mem [MapEntries];

  // Command decode signals
  logic [11:0] half_cols, half_rows;
  logic signed [12:0] dx, dy;
  logic [17:0] colbs, rowbs;
  logic [23:0] idx_full;
  logic        in_map;
  logic [31:0] lcg_base;
  // Execute signals
  logic [23:0] rowfw, off_sum;
  logic [63:0] rr;
  logic [ROOT_W-1:0] sq_sum;
  logic        sq_start, sq_busy;
  logic [ROOT_OUT_W-1:0] root;
  // Finish signals
  logic [11:0]       cand;
  logic [SLOT_W-1:0] entry, look_dly, look_slot;
  logic [SLOT_W:0]   look_sum;
  logic              cmd_pop, res_push, res_full, mem_we, rings_build;
  res_t              res_d;

  // Decode coordinates: mirrored distance from centre, block products, map index
  always_comb begin
    half_cols = cfg_i.map_cols - (cfg_i.map_cols >> 1);
    half_rows = cfg_i.map_rows - (cfg_i.map_rows >> 1);
    dx        = $signed({1'b0, half_cols}) - $signed({2'b00, cmd_i.col});
    dy        = $signed({1'b0, half_rows}) - $signed({2'b00, cmd_i.row});
    colbs     = 18'(cmd_i.col) * 18'(cfg_i.block_size);
    rowbs     = 18'(cmd_i.row) * 18'(cfg_i.block_size);
    idx_full  = 24'(cmd_i.row) * 24'(cfg_i.map_cols) + 24'(cmd_i.col);
    in_map    = ({1'b0, cmd_i.row} < cfg_i.map_rows) &&
                ({1'b0, cmd_i.col} < cfg_i.map_cols) &&
                (idx_full < 24'(MapEntries));
    lcg_base  = cmd_i.first ? cfg_i.seed : lcg_q;
    lcg_d     = lcg_q;
    if (cmd_pop && (cmd_i.op == OP_BUILD)) begin
      lcg_d = (cfg_i.mode == MODE_RANDOM) ? (lcg_base * LCG_MUL + LCG_INC) : lcg_base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      op_q     <= cmd_i.op;
      colbs_q  <= colbs;
      rowbs_q  <= rowbs;
      idx_q    <= idx_full;
      in_map_q <= in_map;
      adx_q    <= dx[12] ? 12'(-dx) : 12'(dx);
      ady_q    <= dy[12] ? 12'(-dy) : 12'(dy);
    end
  end

  // Execute: byte offset, squared random value, ring distance, map read
  assign rowfw       = 24'(rowbs_q) * 24'(cfg_i.frame_width);
  assign off_sum     = rowfw + 24'(colbs_q);
  assign rr          = 64'(lcg_q) * 64'(lcg_q);
  assign sq_sum      = ROOT_W'(adx_q) * ROOT_W'(adx_q) + ROOT_W'(ady_q) * ROOT_W'(ady_q);
  assign rings_build = (op_q == OP_BUILD) && (cfg_i.mode == MODE_RINGS);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      off_q <= {off_sum, 2'b00};
      rnd_q <= rr[63:58];
    end
  end

  // Delay map: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      delay_mem[idx_q[AddrW-1:0]] <= entry;
    end
    if (state_q == ST_EXEC) begin
      mem_rd_q <= delay_mem[idx_q[AddrW-1:0]];
    end
  end

  bfda_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_sum),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // Finish: select and clip the entry, form the slot
  always_comb begin
    unique case (cfg_i.mode)
      MODE_RANDOM:  cand = 12'(rnd_q);
      MODE_VSTRIPE: cand = adx_q >> 1;
      MODE_HSTRIPE: cand = ady_q >> 1;
      MODE_RINGS:   cand = root >> 1;
      default:      cand = '0;
    endcase
    entry     = (cand > 12'(QdMax)) ? QdMax : cand[SLOT_W-1:0];
    look_dly  = in_map_q ? mem_rd_q : '0;
    look_sum  = {1'b0, head_q} + {1'b0, look_dly};
    look_slot = (look_sum >= (SLOT_W+1)'(QueueDepth)) ?
                SLOT_W'(look_sum - (SLOT_W+1)'(QueueDepth)) : look_sum[SLOT_W-1:0];
    head_d    = (head_q == '0) ? QdMax : head_q - 1'b1;
    res_d     = '0;
    unique case (op_q)
      OP_BUILD: begin
        res_d.byte_offset = off_q;
        res_d.delay       = entry;
      end
      OP_ADVANCE: res_d.slot = head_d;
      OP_LOOKUP: begin
        res_d.slot        = look_slot;
        res_d.byte_offset = off_q;
        res_d.delay       = look_dly;
      end
      OP_NONE: ;
    endcase
  end

  // Sequence one command: take, execute, optional root, finish
  always_comb begin
    state_d  = state_q;
    cmd_pop  = 1'b0;
    sq_start = 1'b0;
    res_push = 1'b0;
    mem_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (rings_build) begin
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          mem_we   = (op_q == OP_BUILD) && in_map_q;
          if (cmd_valid_i) begin
            cmd_pop = 1'b1;
            state_d = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  assign cmd_pop_o = cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      lcg_q   <= '0;
    end else begin
      state_q <= state_d;
      lcg_q   <= lcg_d;
      if (res_push && (op_q == OP_ADVANCE)) begin
        head_q <= head_d;
      end
    end
  end

  // Hold finished results until they are taken
  bfda_fifo #(
    .Width ($bits(res_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .empty_o (res_empty_o)
  );

  `BFDA_ASSERT(a_root_idle_outside_seq, (state_q == ST_IDLE) |-> !sq_busy)
  `BFDA_ASSERT(a_root_only_rings, (state_q == ST_ROOT) |-> rings_build)
  `BFDA_ASSERT(a_head_moves_on_advance, !(res_push && (op_q == OP_ADVANCE)) |=> $stable(head_q))
  `BFDA_ASSERT_ALWAYS(a_head_in_ring, !rst_ni || (head_q < SLOT_W'(QueueDepth)))

endmodule

### rtl/core/block_frame_delay_address_core.sv
// Top level of the frame delay address core.
//
//  channel   handshake                         payload
//  --------  --------------------------------  ----------------------------------
//  items     push / full (taken: push & !full) func_i, first_i, row_i, col_i
//  results   empty / pop (taken: pop & !empty) slot_o, byte_offset_o, delay_o
//  registers psel penable pwrite / pready      paddr (4 bytes per reg), pwdata, prdata
//
// A command passes the back end in steps: queue pop with block and index multiplies,
// then offset product, generator square and map read, then a finish step that
// overlaps the next pop and waits while the result queue is full. A rings build
// adds a wait on the 12-step square root unit. Two-entry queues sit on both sides,
// so items are taken while results wait. Reset clears control state, the ring head
// and the generator; the delay map holds no reset and needs no clearing pass.
module block_frame_delay_address_core import bfda_pkg::*; #(
  parameter int unsigned QueueDepth = 71,
  parameter int unsigned MapEntries = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            func_i,
  input  logic                  first_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [COORD_W-1:0]    col_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [OFFSET_W-1:0]   byte_offset_o,
  output logic [SLOT_W-1:0]     delay_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop;

  bfda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .first_i     (first_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bfda_back #(
    .QueueDepth (QueueDepth),
    .MapEntries (MapEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign slot_o        = res.slot;
  assign byte_offset_o = res.byte_offset;
  assign delay_o       = res.delay;

endmodule
